/* sv/ida_pkg.sv */
// Shared types and constants for the integer to decimal ASCII converter.
package ida_pkg;

   localparam int VALUE_BITS_DEFAULT = 64;
   localparam int WORD_WIDTH         = 64;
   localparam int CHAR_WIDTH         = 8;
   localparam int BCD_WIDTH          = 4;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'd45;

   localparam logic [BCD_WIDTH-1:0] BCD_ADJUST_LIMIT = 4'd5;
   localparam logic [BCD_WIDTH-1:0] BCD_ADJUST       = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic push_sign;
      logic push_digit;
   } cmd_type;

   typedef struct packed {
      logic neg;
      logic conv_last;
      logic last_digit;
   } status_type;

endpackage

/* sv/ida_stream_if.sv */
// Valid/ready channel interfaces for the request and response streams.
interface ida_req_if;
   logic                               valid;
   logic                               ready;
   logic [ida_pkg::WORD_WIDTH-1:0]     value;
   logic                               is_signed;

   modport source (output valid, output value, output is_signed, input ready);
   modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface ida_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ida_pkg::CHAR_WIDTH-1:0]     character;
   logic                               last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

/* sv/ida_datapath.sv */
// Datapath: magnitude register, shift-add-3 BCD converter and output character register.
module ida_datapath #(
   parameter int VALUE_BITS = ida_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  ida_pkg::cmd_type                  cmd,
   input  logic [ida_pkg::WORD_WIDTH-1:0]    value,
   input  logic                              is_signed,
   output ida_pkg::status_type               status,
   output logic [ida_pkg::CHAR_WIDTH-1:0]    character,
   output logic                              last_char
);

   localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int IDXW   = $clog2(DIGITS);
   localparam int NW     = $clog2(DIGITS + 1);
   localparam int CW     = $clog2(VALUE_BITS + 1);
   localparam logic [NW-1:0] DIGIT_COUNT = NW'(DIGITS);
   localparam logic [CW-1:0] BIT_COUNT   = CW'(VALUE_BITS);
   localparam logic [CW-1:0] CNT_ONE     = CW'(1);
   localparam logic [NW-1:0] NDIG_ONE    = NW'(1);

   logic [VALUE_BITS-1:0]         mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [NW-1:0]                 ndig_ff, ndig_in;
   logic [ida_pkg::BCD_WIDTH-1:0] bcd_ff [DIGITS];
   logic [ida_pkg::BCD_WIDTH-1:0] bcd_in [DIGITS];
   logic [ida_pkg::BCD_WIDTH-1:0] adj    [DIGITS];
   logic [ida_pkg::BCD_WIDTH-1:0] step   [DIGITS];
   logic [ida_pkg::CHAR_WIDTH-1:0] char_ff, char_in;
   logic                          last_ff, last_in;

   logic [VALUE_BITS-1:0] masked;
   logic                  load_neg;
   logic [NW-1:0]         ptr_m1;
   logic [IDXW-1:0]       emit_idx;
   logic [IDXW-1:0]       grow_idx;

   assign masked   = value[VALUE_BITS-1:0];
   assign load_neg = is_signed & masked[VALUE_BITS-1];
   assign ptr_m1   = ndig_ff - NDIG_ONE;
   assign emit_idx = (ndig_ff == '0) ? '0 : ptr_m1[IDXW-1:0];
   assign grow_idx = ndig_ff[IDXW-1:0];

   // One double-dabble step: correct every digit, then shift in the next magnitude bit.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= ida_pkg::BCD_ADJUST_LIMIT) ?
                  bcd_ff[i] + ida_pkg::BCD_ADJUST : bcd_ff[i];
      end
      step[0] = {adj[0][ida_pkg::BCD_WIDTH-2:0], mag_ff[VALUE_BITS-1]};
      for (int i = 1; i < DIGITS; i++) begin
         step[i] = {adj[i][ida_pkg::BCD_WIDTH-2:0], adj[i-1][ida_pkg::BCD_WIDTH-1]};
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      ndig_in = ndig_ff;
      bcd_in  = bcd_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.load) begin
         neg_in  = load_neg;
         mag_in  = load_neg ? (~masked + 1'b1) : masked;
         cnt_in  = BIT_COUNT;
         ndig_in = '0;
         for (int i = 0; i < DIGITS; i++) begin
            bcd_in[i] = '0;
         end
      end else if (cmd.shift) begin
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_ONE;
         bcd_in = step;
         // The digit count grows by at most one per doubling.
         if ((ndig_ff < DIGIT_COUNT) && (step[grow_idx] != '0)) begin
            ndig_in = ndig_ff + NDIG_ONE;
         end
      end else if (cmd.push_sign) begin
         char_in = ida_pkg::ASCII_MINUS;
         last_in = 1'b0;
      end else if (cmd.push_digit) begin
         char_in = ida_pkg::ASCII_ZERO + {4'b0000, bcd_ff[emit_idx]};
         last_in = (ndig_ff <= NDIG_ONE);
         if (ndig_ff != '0) begin
            ndig_in = ptr_m1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      ndig_ff <= ndig_in;
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.neg        = neg_ff;
   assign status.conv_last  = (cnt_ff == CNT_ONE);
   assign status.last_digit = (ndig_ff <= NDIG_ONE);
   assign character         = char_ff;
   assign last_char         = last_ff;

endmodule

/* sv/ida_controller.sv */
// Controller: sequences load, conversion, sign and digit output, and owns the output valid flag.
module ida_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  ida_pkg::status_type   status,
   output ida_pkg::cmd_type      cmd
);

   ida_pkg::state_type state_ff, state_in;
   logic               valid_ff, valid_in;
   logic               slot_free;

   assign slot_free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ida_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ida_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ida_pkg::ST_CONVERT;
            end
         end
         ida_pkg::ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (status.conv_last) begin
               state_in = status.neg ? ida_pkg::ST_SIGN : ida_pkg::ST_EMIT;
            end
         end
         ida_pkg::ST_SIGN: begin
            if (slot_free) begin
               cmd.push_sign = 1'b1;
               state_in      = ida_pkg::ST_EMIT;
            end
         end
         ida_pkg::ST_EMIT: begin
            if (slot_free) begin
               cmd.push_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ida_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = ida_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.push_sign || cmd.push_digit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

/* sv/integer_to_decimal_ascii.sv */
// Top level of the integer to decimal ASCII converter: controller, datapath and checks.
// The request is loaded, converted by the one-bit-per-cycle shift-add-3 BCD loop, and
// then sent out one character per cycle, while the receiver takes them, through the single
// output register. A new request is accepted only after the last digit has been written there.
// Reset: synchronous, active high; clears the controller state and the output valid flag.
module integer_to_decimal_ascii #(
   parameter int VALUE_BITS = ida_pkg::VALUE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ida_req_if.sink    req_chan,
   ida_rsp_if.source  rsp_chan
);

   // Besides the handshakes, the controller only sees command and status structs; all payload lives in the datapath.
   ida_pkg::cmd_type    cmd;
   ida_pkg::status_type status;

   ida_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath converts the magnitude to BCD one bit per cycle, counts the significant
   // digits as they appear, and then hands them out most significant first.
   ida_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .value     (req_chan.value),
      .is_signed (req_chan.is_signed),
      .status    (status),
      .character (rsp_chan.character),
      .last_char (rsp_chan.last_char)
   );

`ifndef SYNTH
   // A new number is only loaded on an accepted request transaction.
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_chan.valid && req_chan.ready))
      else $error("load without an accepted request");

   // The controller issues at most one datapath command per cycle.
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.shift, cmd.push_sign, cmd.push_digit}))
      else $error("more than one datapath command");

   // A character is never written over one that is still waiting to be taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_sign || cmd.push_digit) |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("output character overwritten");

   // Every character shown is a minus sign or a decimal digit, and a minus is never last.
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((rsp_chan.character == ida_pkg::ASCII_MINUS && !rsp_chan.last_char)
         || (rsp_chan.character >= ida_pkg::ASCII_ZERO
             && rsp_chan.character <= ida_pkg::ASCII_ZERO + 8'd9)))
      else $error("illegal output character");
`endif

endmodule

/* verif/tb_integer_to_decimal_ascii.sv */
// Testbench for the integer to decimal ASCII converter: directed and random words, self-checking.
`timescale 1ns / 1ps

module tb_integer_to_decimal_ascii;

   // The DUT is built with its default word width, and the predictor follows it.
   localparam int TB_VALUE_BITS = ida_pkg::VALUE_BITS_DEFAULT;
   localparam logic [ida_pkg::WORD_WIDTH-1:0] WORD_MASK =
      {ida_pkg::WORD_WIDTH{1'b1}} >> (ida_pkg::WORD_WIDTH - TB_VALUE_BITS);
   localparam logic [ida_pkg::WORD_WIDTH-1:0] SIGN_BIT =
      {{(ida_pkg::WORD_WIDTH-1){1'b0}}, 1'b1} << (TB_VALUE_BITS - 1);
   localparam logic [ida_pkg::WORD_WIDTH-1:0] DECIMAL_BASE = 64'd10;
   localparam int MAX_DIGITS   = 20;
   localparam int MAX_IDLE     = 12;
   localparam int REPORT_LIMIT = 10;
   // Cycles to keep watching after the last character, enough for a whole conversion.
   localparam int TAIL_CYCLES  = TB_VALUE_BITS + MAX_DIGITS + 16;

   // One character of the printed text, as the response channel carries it.
   typedef struct {
      logic [ida_pkg::CHAR_WIDTH-1:0] character;
      logic                           last_char;
   } ascii_char_type;

   logic clock = 1'b0;
   logic reset;

   ida_req_if req_bus ();
   ida_rsp_if rsp_bus ();

   integer_to_decimal_ascii DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Characters still owed by the DUT, oldest first.
   ascii_char_type expected_text[$];
   int             mismatch_count = 0;

   // Largest random wait for each side; zero gives a stretch of full-rate traffic.
   int req_gap_max   = MAX_IDLE;
   int rsp_stall_max = MAX_IDLE;

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Works out the decimal text of one word and queues its characters. A negative
   // signed word gets a minus sign, and its magnitude comes from an unsigned negation
   // so that the most negative value prints in full. Zero yields the single digit zero.
   function automatic void predict_decimal_text(input logic [ida_pkg::WORD_WIDTH-1:0] word,
                                                input logic signed_word);
      logic [ida_pkg::WORD_WIDTH-1:0] magnitude;
      logic [ida_pkg::WORD_WIDTH-1:0] remainder;
      logic [ida_pkg::BCD_WIDTH-1:0]  digits [MAX_DIGITS];
      int                             num_digits;
      ascii_char_type                 ch;
      magnitude  = word & WORD_MASK;
      num_digits = 0;
      if (signed_word && ((magnitude & SIGN_BIT) != '0)) begin
         ch.character = ida_pkg::ASCII_MINUS;
         ch.last_char = 1'b0;
         expected_text.push_back(ch);
         magnitude = (~magnitude + 1'b1) & WORD_MASK;
      end
      if (magnitude == '0) begin
         ch.character = ida_pkg::ASCII_ZERO;
         ch.last_char = 1'b1;
         expected_text.push_back(ch);
      end else begin
         // Digits come out least significant first, so they are stored and replayed.
         while (magnitude != '0 && num_digits < MAX_DIGITS) begin
            remainder          = magnitude % DECIMAL_BASE;
            digits[num_digits] = remainder[ida_pkg::BCD_WIDTH-1:0];
            num_digits++;
            magnitude = magnitude / DECIMAL_BASE;
         end
         for (int i = num_digits - 1; i >= 0; i--) begin
            ch.character = ida_pkg::ASCII_ZERO +
               {{(ida_pkg::CHAR_WIDTH-ida_pkg::BCD_WIDTH){1'b0}}, digits[i]};
            ch.last_char = (i == 0);
            expected_text.push_back(ch);
         end
      end
   endfunction

   // Draws a word from a mix of shapes: full random, narrowed by a random shift,
   // small negative numbers, and values next to a power of ten where the digit
   // count changes.
   function automatic logic [ida_pkg::WORD_WIDTH-1:0] random_word();
      logic [ida_pkg::WORD_WIDTH-1:0] word;
      logic [ida_pkg::WORD_WIDTH-1:0] power;
      word = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: begin
         end
         1: begin
            word = word >> $urandom_range(0, ida_pkg::WORD_WIDTH - 1);
         end
         2: begin
            word = ~{32'd0, 32'($urandom_range(0, 1000))} + 1'b1;
         end
         default: begin
            power = 64'd1;
            repeat ($urandom_range(0, MAX_DIGITS - 1)) power = power * DECIMAL_BASE;
            word = power + 64'($urandom_range(0, 2)) - 64'd1;
         end
      endcase
      return word;
   endfunction

   // Sends one word as a request transaction after a random gap, and queues its
   // text once the DUT has accepted it. Valid stays high when the next word follows
   // with no gap, so it is never lowered and raised in one time step.
   task automatic send_word(input logic [ida_pkg::WORD_WIDTH-1:0] word,
                            input logic signed_word);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.value     <= word;
      req_bus.is_signed <= signed_word;
      do @(posedge clock); while (!req_bus.ready);
      predict_decimal_text(word, signed_word);
   endtask

   // Stops sending and waits until every queued character has come back.
   task automatic wait_text_drained();
      req_bus.valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
   endtask

   function automatic void note_mismatch(input string what, input ascii_char_type want,
                                         input ascii_char_type got);
      if (mismatch_count < REPORT_LIMIT)
         $display("mismatch (%s): expected char %0d last %0b, got char %0d last %0b",
                  what, want.character, want.last_char, got.character, got.last_char);
      mismatch_count++;
   endfunction

   // Response side: random stalls on ready, drawn anew for every transaction.
   initial begin : drive_rsp_ready
      int stall;
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // Compares every accepted character with the oldest one still owed.
   always @(posedge clock) begin : check_text
      ascii_char_type want;
      ascii_char_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.character = rsp_bus.character;
         got.last_char = rsp_bus.last_char;
         if (expected_text.size() == 0) begin
            want.character = '0;
            want.last_char = 1'b0;
            note_mismatch("nothing expected", want, got);
         end else begin
            want = expected_text.pop_front();
            if (got.character !== want.character || got.last_char !== want.last_char)
               note_mismatch("wrong field", want, got);
         end
      end
   end

   // Extremes of the word, both sign modes, the most negative value, zero,
   // bits of the full word and the digit-count boundaries.
   task automatic test_directed_words();
      req_gap_max   = 4;
      rsp_stall_max = 4;
      send_word(64'd0, 1'b0);
      send_word(64'd0, 1'b1);
      send_word(64'd1, 1'b0);
      send_word(64'd9, 1'b1);
      send_word(64'd10, 1'b0);
      send_word(64'd99, 1'b0);
      send_word(64'd100, 1'b1);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_word(64'h8000_0000_0000_0000, 1'b1);
      send_word(64'h8000_0000_0000_0000, 1'b0);
      send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      send_word(64'd9999999999999999999, 1'b0);
      send_word(64'd10000000000000000000, 1'b0);
      send_word(64'hFFFF_FFFF_FFFF_FFF6, 1'b1);
      send_word(64'h0000_0000_FFFF_FFFF, 1'b0);
      send_word(64'h0000_0000_8000_0000, 1'b1);
      send_word(64'hFFFF_FFFF_8000_0000, 1'b1);
      send_word(64'h5555_5555_5555_5555, 1'b1);
      send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
   endtask

   // Words presented with no gaps and taken with no stalls.
   task automatic test_full_rate();
      req_gap_max   = 0;
      rsp_stall_max = 0;
      repeat (60) send_word(random_word(), 1'($urandom_range(0, 1)));
   endtask

   // The bulk of the random traffic, with both sides idling at random.
   task automatic test_random_idle();
      req_gap_max   = MAX_IDLE;
      rsp_stall_max = MAX_IDLE;
      repeat (300) send_word(random_word(), 1'($urandom_range(0, 1)));
   endtask

   // The sender stops until the DUT has delivered every owed character, then resumes.
   task automatic test_drain_pause();
      req_gap_max   = 2;
      rsp_stall_max = 6;
      repeat (10) send_word(random_word(), 1'($urandom_range(0, 1)));
      wait_text_drained();
      repeat (10) send_word(random_word(), 1'($urandom_range(0, 1)));
   endtask

   // A receiver that stalls a lot behind a sender that never waits.
   task automatic test_slow_receiver();
      req_gap_max   = 0;
      rsp_stall_max = MAX_IDLE;
      repeat (60) send_word(random_word(), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.value     <= '0;
      req_bus.is_signed <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_words();
      test_full_rate();
      test_random_idle();
      test_drain_pause();
      test_slow_receiver();

      // Wait for the last owed character, then watch a while longer for strays.
      wait_text_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_text.size() == 0) begin
         $display("PASS integer_to_decimal_ascii");
      end else begin
         $display("FAIL integer_to_decimal_ascii");
      end
      $finish;
   end

   // Watchdog, set well beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("timeout with %0d characters still owed", expected_text.size());
      $display("FAIL integer_to_decimal_ascii");
      $finish;
   end

endmodule
